FILE: design/lph_pkg.sv
// Package for the linear probing hash index.
// Holds the operation, status and controller state codes and the table entry layout.
// It has no dependencies.
package lph_pkg;

   localparam int KEY_W      = 32;
   localparam int HANDLE_W   = 32;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B9;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_MISS     = 3'd1,
      STATUS_DUP      = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_MISMATCH = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_HOME,
      S_PROBE,
      S_ERASE_DATA,
      S_ERASE_CMP,
      S_ERASE_END,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } slot_type;

endpackage

FILE: design/lph_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// It has no dependencies.
module lph_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lph_hash.sv
// Multiplicative hash that gives the registered home bucket of a key.
// Depends on lph_pkg for the key width and the multiplier constant.
module lph_hash #(
   parameter int AW = 10
) (
   input  logic                      clock,
   input  logic [lph_pkg::KEY_W-1:0] key_i,
   output logic [AW-1:0]             home_o
);

   logic [lph_pkg::KEY_W-1:0] prod;
   logic [AW-1:0]             home_ff;

   assign prod = key_i * lph_pkg::HASH_MULT;

   always_ff @(posedge clock) begin
      home_ff <= prod[lph_pkg::KEY_W-1 -: AW];
   end

   assign home_o = home_ff;

endmodule

FILE: design/lph_ctrl.sv
// Controller of the hash index: probe walk, insert, backward-shift removal and sweep.
// Depends on lph_pkg; drives the table RAM and the hash unit from the top level.
module lph_ctrl #(
   parameter int SLOTS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  lph_pkg::op_type                req_op,
   input  logic [lph_pkg::KEY_W-1:0]      req_key,
   input  logic [lph_pkg::HANDLE_W-1:0]   req_handle,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output lph_pkg::status_type            rsp_status,
   output logic [lph_pkg::HANDLE_W-1:0]   rsp_handle,
   output logic                           ram_we,
   output logic [$clog2(SLOTS)-1:0]       ram_waddr,
   output lph_pkg::slot_type              ram_wdata,
   output logic [$clog2(SLOTS)-1:0]       ram_raddr,
   input  lph_pkg::slot_type              ram_rdata,
   output logic [lph_pkg::KEY_W-1:0]      hash_key,
   input  logic [$clog2(SLOTS)-1:0]       hash_home
);

   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = AW + 1;
   localparam int LIMIT = SLOTS * 3 / 4;
   localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

   lph_pkg::state_type            state_ff, state_in;
   lph_pkg::op_type               op_ff, op_in;
   logic [lph_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lph_pkg::HANDLE_W-1:0]  handle_ff, handle_in;
   logic [AW-1:0]                 cur_ff, cur_in;
   logic [AW-1:0]                 hole_ff, hole_in;
   logic [AW-1:0]                 steps_ff, steps_in;
   logic [CW-1:0]                 count_ff, count_in;
   lph_pkg::slot_type             move_ff, move_in;
   logic                          sweep_reply_ff, sweep_reply_in;
   lph_pkg::status_type           res_status_ff, res_status_in;
   logic [lph_pkg::HANDLE_W-1:0]  res_handle_ff, res_handle_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lph_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [lph_pkg::HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;

   logic          hit;
   logic          empty;
   logic          stay;
   logic [AW-1:0] cur_next;

   assign hit      = ram_rdata.valid && (ram_rdata.key == key_ff);
   assign empty    = !ram_rdata.valid;
   assign cur_next = cur_ff + AW'(1);

   // An entry whose home lies between the hole and its own slot, in ring order, keeps its place.
   always_comb begin
      if (hole_ff <= cur_ff) begin
         stay = (hole_ff < hash_home) && (hash_home <= cur_ff);
      end else begin
         stay = (hole_ff < hash_home) || (hash_home <= cur_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lph_pkg::S_SWEEP;
         cur_ff         <= '0;
         count_ff       <= '0;
         sweep_reply_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_ff         <= cur_in;
         count_ff       <= count_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      hole_ff       <= hole_in;
      steps_ff      <= steps_in;
      move_ff       <= move_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      cur_in         = cur_ff;
      hole_in        = hole_ff;
      steps_in       = steps_ff;
      count_in       = count_ff;
      move_in        = move_ff;
      sweep_reply_in = sweep_reply_ff;
      res_status_in  = res_status_ff;
      res_handle_in  = res_handle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      req_tready     = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = hole_ff;
      ram_wdata      = '0;
      ram_raddr      = cur_ff;
      hash_key       = req_key;

      case (state_ff)
         lph_pkg::S_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff;
            count_in  = '0;
            cur_in    = cur_next;
            if (cur_ff == LAST) begin
               if (sweep_reply_ff) begin
                  res_status_in = lph_pkg::STATUS_OK;
                  res_handle_in = '0;
                  state_in      = lph_pkg::S_REPLY;
               end else begin
                  state_in = lph_pkg::S_IDLE;
               end
            end
         end
         lph_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = req_op;
               key_in    = req_key;
               handle_in = req_handle;
               if (req_op == lph_pkg::OP_CLEAR) begin
                  cur_in         = '0;
                  sweep_reply_in = 1'b1;
                  state_in       = lph_pkg::S_SWEEP;
               end else begin
                  state_in = lph_pkg::S_HOME;
               end
            end
         end
         lph_pkg::S_HOME: begin
            ram_raddr = hash_home;
            cur_in    = hash_home;
            steps_in  = '0;
            state_in  = lph_pkg::S_PROBE;
         end
         lph_pkg::S_PROBE: begin
            res_handle_in = '0;
            if (hit || empty || (steps_ff == LAST)) begin
               state_in = lph_pkg::S_REPLY;
               case (op_ff)
                  lph_pkg::OP_LOOKUP: begin
                     if (hit) begin
                        res_status_in = lph_pkg::STATUS_OK;
                        res_handle_in = ram_rdata.handle;
                     end else begin
                        res_status_in = lph_pkg::STATUS_MISS;
                     end
                  end
                  lph_pkg::OP_INSERT: begin
                     if (hit) begin
                        res_status_in = lph_pkg::STATUS_DUP;
                     end else if ((count_ff >= CW'(LIMIT)) || !empty) begin
                        res_status_in = lph_pkg::STATUS_FULL;
                     end else begin
                        ram_we           = 1'b1;
                        ram_waddr        = cur_ff;
                        ram_wdata.valid  = 1'b1;
                        ram_wdata.key    = key_ff;
                        ram_wdata.handle = handle_ff;
                        count_in         = count_ff + CW'(1);
                        res_status_in    = lph_pkg::STATUS_OK;
                     end
                  end
                  lph_pkg::OP_REMOVE: begin
                     if (!hit) begin
                        res_status_in = lph_pkg::STATUS_MISS;
                     end else if (ram_rdata.handle != handle_ff) begin
                        res_status_in = lph_pkg::STATUS_MISMATCH;
                     end else begin
                        hole_in   = cur_ff;
                        ram_raddr = cur_next;
                        cur_in    = cur_next;
                        steps_in  = '0;
                        state_in  = lph_pkg::S_ERASE_DATA;
                     end
                  end
                  default: begin
                     res_status_in = lph_pkg::STATUS_OK;
                  end
               endcase
            end else begin
               ram_raddr = cur_next;
               cur_in    = cur_next;
               steps_in  = steps_ff + AW'(1);
            end
         end
         lph_pkg::S_ERASE_DATA: begin
            move_in  = ram_rdata;
            hash_key = ram_rdata.key;
            if (empty) begin
               state_in = lph_pkg::S_ERASE_END;
            end else begin
               state_in = lph_pkg::S_ERASE_CMP;
            end
         end
         lph_pkg::S_ERASE_CMP: begin
            if (!stay) begin
               ram_we    = 1'b1;
               ram_waddr = hole_ff;
               ram_wdata = move_ff;
               hole_in   = cur_ff;
            end
            if (steps_ff == LAST) begin
               state_in = lph_pkg::S_ERASE_END;
            end else begin
               ram_raddr = cur_next;
               cur_in    = cur_next;
               steps_in  = steps_ff + AW'(1);
               state_in  = lph_pkg::S_ERASE_DATA;
            end
         end
         lph_pkg::S_ERASE_END: begin
            ram_we    = 1'b1;
            ram_waddr = hole_ff;
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
            res_status_in = lph_pkg::STATUS_OK;
            res_handle_in = '0;
            state_in      = lph_pkg::S_REPLY;
         end
         lph_pkg::S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               state_in      = lph_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lph_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle = rsp_handle_ff;

endmodule

FILE: design/linear_probe_hash_index.sv
// Lookup and insert probe from the home bucket until a hit, an empty slot or a full lap;
// the block takes the next item only after the result of the last one has been offered.
// A remove that deletes an entry then runs a backward shift over the occupied slots that
// follow it. Clear sweeps every slot of the table. After reset a sweep clears the table
// before the first item is taken. Reset is synchronous and active high.
module linear_probe_hash_index #(
   parameter int SLOTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lph_pkg::REQ_DATA_W-1:0]  req_tdata,  // key, handle
   input  logic [lph_pkg::OP_W-1:0]        req_tuser,  // op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lph_pkg::RSP_DATA_W-1:0]  rsp_tdata   // status, handle_out, zero fill
);

   localparam int AW = $clog2(SLOTS);

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr;
   lph_pkg::slot_type              ram_wdata;
   logic [AW-1:0]                  ram_raddr;
   lph_pkg::slot_type              ram_rdata;
   logic [$bits(lph_pkg::slot_type)-1:0] ram_rdata_raw;
   logic [lph_pkg::KEY_W-1:0]      hash_key;
   logic [AW-1:0]                  hash_home;
   lph_pkg::status_type            rsp_status;
   logic [lph_pkg::HANDLE_W-1:0]   rsp_handle;

   assign ram_rdata = lph_pkg::slot_type'(ram_rdata_raw);

   lph_ram #(
      .WIDTH ($bits(lph_pkg::slot_type)),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   lph_hash #(
      .AW (AW)
   ) u_hash (
      .clock  (clock),
      .key_i  (hash_key),
      .home_o (hash_home)
   );

   lph_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (lph_pkg::op_type'(req_tuser)),
      .req_key    (req_tdata[lph_pkg::KEY_W-1:0]),
      .req_handle (req_tdata[lph_pkg::KEY_W +: lph_pkg::HANDLE_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_handle (rsp_handle),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .hash_key   (hash_key),
      .hash_home  (hash_home)
   );

   assign rsp_tdata = {
      {(lph_pkg::RSP_DATA_W - lph_pkg::STATUS_W - lph_pkg::HANDLE_W){1'b0}},
      rsp_handle,
      rsp_status
   };

endmodule

FILE: dv/linear_probe_hash_index_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the linear probing hash index: watches both streams, keeps its own table.
// Depends on lph_pkg for the operation and status codes.
module linear_probe_hash_index_checker #(
   parameter int SLOTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lph_pkg::REQ_DATA_W-1:0]  req_tdata,  // key, handle
   input  logic [lph_pkg::OP_W-1:0]        req_tuser,  // op
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [lph_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // status, handle_out, zero fill
   output int                              fail_count,
   output int                              pending_count
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [31:0] GOLDEN_MULT = 32'h9E37_79B9;

   typedef struct packed {
      lph_pkg::status_type status;
      logic [31:0]         handle;
   } reply_type;

   reply_type   expected_replies[$];
   reply_type   want;
   logic [31:0] tab_key    [SLOTS];
   logic [31:0] tab_handle [SLOTS];
   bit          tab_valid  [SLOTS];
   int          live_entries = 0;
   int          mismatches = 0;
   int          outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   initial begin
      foreach (tab_valid[n]) tab_valid[n] = 1'b0;
   end

   function automatic logic [IDX_W-1:0] home_bucket(input logic [31:0] key);
      logic [31:0] prod;
      prod = key * GOLDEN_MULT;
      return prod[31 -: IDX_W];
   endfunction

   function automatic bit locate_key(input logic [31:0] key, output logic [IDX_W-1:0] pos);
      logic [IDX_W-1:0] idx;
      int n;
      idx = home_bucket(key);
      for (n = 0; n < SLOTS; n++) begin
         pos = idx;
         if (!tab_valid[idx]) return 1'b0;
         if (tab_key[idx] == key) return 1'b1;
         idx = idx + IDX_W'(1);
      end
      pos = idx;
      return 1'b0;
   endfunction

   // Backward-shift deletion: pull later entries into the hole unless their home
   // lies cyclically between the hole and their current slot.
   function automatic void close_gap(input logic [IDX_W-1:0] hole);
      logic [IDX_W-1:0] gap;
      logic [IDX_W-1:0] scan;
      logic [IDX_W-1:0] home;
      bit keep;
      int n;
      gap = hole;
      scan = hole;
      tab_valid[hole] = 1'b0;
      for (n = 0; n < SLOTS; n++) begin
         scan = scan + IDX_W'(1);
         if (!tab_valid[scan]) break;
         home = home_bucket(tab_key[scan]);
         if (gap <= scan) keep = (gap < home) && (home <= scan);
         else keep = (gap < home) || (home <= scan);
         if (!keep) begin
            tab_key[gap]    = tab_key[scan];
            tab_handle[gap] = tab_handle[scan];
            tab_valid[gap]  = 1'b1;
            tab_valid[scan] = 1'b0;
            gap = scan;
         end
      end
      if (live_entries > 0) live_entries--;
   endfunction

   function automatic reply_type apply_request(input lph_pkg::op_type op,
                                               input logic [31:0] key,
                                               input logic [31:0] handle);
      reply_type r;
      logic [IDX_W-1:0] pos;
      bit hit;
      int n;
      r.status = lph_pkg::STATUS_OK;
      r.handle = '0;
      case (op)
         lph_pkg::OP_LOOKUP: begin
            hit = locate_key(key, pos);
            if (hit) r.handle = tab_handle[pos];
            else r.status = lph_pkg::STATUS_MISS;
         end
         lph_pkg::OP_INSERT: begin
            hit = locate_key(key, pos);
            if (hit) begin
               r.status = lph_pkg::STATUS_DUP;
            end else if ((live_entries + 1) * 4 > SLOTS * 3 || tab_valid[pos]) begin
               r.status = lph_pkg::STATUS_FULL;
            end else begin
               tab_key[pos]    = key;
               tab_handle[pos] = handle;
               tab_valid[pos]  = 1'b1;
               live_entries++;
            end
         end
         lph_pkg::OP_REMOVE: begin
            hit = locate_key(key, pos);
            if (!hit) r.status = lph_pkg::STATUS_MISS;
            else if (tab_handle[pos] != handle) r.status = lph_pkg::STATUS_MISMATCH;
            else close_gap(pos);
         end
         default: begin
            for (n = 0; n < SLOTS; n++) tab_valid[n] = 1'b0;
            live_entries = 0;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] expected_val,
                                  input logic [31:0] actual_val);
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, expected_val, actual_val,
               $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(apply_request(lph_pkg::op_type'(req_tuser),
                                                     req_tdata[31:0], req_tdata[63:32]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected item", '0, rsp_tdata[34:3]);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tdata[2:0] !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_tdata[2:0]));
               if (rsp_tdata[34:3] !== want.handle)
                  report_mismatch("handle_out", want.handle, rsp_tdata[34:3]);
            end
         end
         outstanding = expected_replies.size();
      end
   end

endmodule

FILE: dv/linear_probe_hash_index_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the linear probing hash index: clock, reset, stimulus and verdict.
// Depends on lph_pkg, the block and linear_probe_hash_index_checker.
module linear_probe_hash_index_tb;

   localparam int SLOTS = 1024;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [lph_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [lph_pkg::OP_W-1:0]       req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [lph_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                             fail_count;
   int                             pending_count;

   bit          quiet = 1'b0;
   int          hold_left = 0;
   int          cycle_count = 0;
   logic [31:0] mult_inv;
   logic [31:0] pool_key[$];
   logic [31:0] pool_handle[$];

   linear_probe_hash_index #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   linear_probe_hash_index_checker #(.SLOTS(SLOTS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 26);
         end
      end
   end

   task automatic send_item(input lph_pkg::op_type op, input logic [31:0] key,
                            input logic [31:0] handle);
      int gap;
      gap = 0;
      while (!quiet && $urandom_range(0, 99) < 26) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {handle, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // One key in five lands in a cluster whose homes straddle the wrap of the table.
   function automatic logic [31:0] fresh_key();
      if ($urandom_range(0, 4) == 0)
         return mult_inv * {10'($urandom_range(1018, 1029)), 22'($urandom)};
      return $urandom;
   endfunction

   task automatic send_mixed(input int w_ins, input int w_look, input int w_rem);
      int pick;
      int sel;
      logic [31:0] k;
      logic [31:0] h;
      pick = $urandom_range(0, w_ins + w_look + w_rem - 1);
      if ($urandom_range(0, 399) == 0) begin
         send_item(lph_pkg::OP_CLEAR, $urandom, $urandom);
         pool_key.delete();
         pool_handle.delete();
      end else if (pick < w_ins) begin
         if (pool_key.size() > 0 && $urandom_range(0, 9) == 0) begin
            sel = $urandom_range(0, pool_key.size() - 1);
            send_item(lph_pkg::OP_INSERT, pool_key[sel], $urandom);
         end else begin
            k = fresh_key();
            h = $urandom;
            send_item(lph_pkg::OP_INSERT, k, h);
            pool_key.push_back(k);
            pool_handle.push_back(h);
         end
      end else if (pick < w_ins + w_look) begin
         if (pool_key.size() > 0 && $urandom_range(0, 3) != 0) begin
            sel = $urandom_range(0, pool_key.size() - 1);
            send_item(lph_pkg::OP_LOOKUP, pool_key[sel], $urandom);
         end else begin
            send_item(lph_pkg::OP_LOOKUP, fresh_key(), $urandom);
         end
      end else begin
         if (pool_key.size() > 0 && $urandom_range(0, 9) != 0) begin
            sel = $urandom_range(0, pool_key.size() - 1);
            if ($urandom_range(0, 9) == 0) begin
               send_item(lph_pkg::OP_REMOVE, pool_key[sel],
                         pool_handle[sel] ^ (32'd1 << $urandom_range(0, 31)));
            end else begin
               send_item(lph_pkg::OP_REMOVE, pool_key[sel], pool_handle[sel]);
               pool_key.delete(sel);
               pool_handle.delete(sel);
            end
         end else begin
            send_item(lph_pkg::OP_REMOVE, fresh_key(), $urandom);
         end
      end
   endtask

   initial begin
      int i;
      logic [31:0] wrap_keys [6];
      logic [31:0] wrap_handles [6];
      logic [31:0] k;
      logic [31:0] h;

      mult_inv = lph_pkg::HASH_MULT;
      repeat (5) mult_inv = mult_inv * (32'd2 - lph_pkg::HASH_MULT * mult_inv);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_item(lph_pkg::OP_LOOKUP, 32'd0, 32'd0);
      send_item(lph_pkg::OP_REMOVE, '1, 32'd0);
      send_item(lph_pkg::OP_INSERT, 32'd0, 32'd0);
      send_item(lph_pkg::OP_INSERT, '1, '1);
      send_item(lph_pkg::OP_INSERT, 32'd0, 32'h1234_5678);
      send_item(lph_pkg::OP_LOOKUP, 32'd0, '1);
      send_item(lph_pkg::OP_LOOKUP, '1, 32'd0);
      send_item(lph_pkg::OP_REMOVE, '1, 32'h7FFF_FFFF);
      send_item(lph_pkg::OP_REMOVE, '1, '1);
      send_item(lph_pkg::OP_LOOKUP, '1, 32'd0);
      // All six keys share the last bucket, so the run wraps past slot zero.
      for (i = 0; i < 6; i++) begin
         wrap_keys[i]    = mult_inv * {10'h3FF, 22'($urandom)};
         wrap_handles[i] = $urandom;
         send_item(lph_pkg::OP_INSERT, wrap_keys[i], wrap_handles[i]);
      end
      send_item(lph_pkg::OP_REMOVE, wrap_keys[0], wrap_handles[0]);
      send_item(lph_pkg::OP_LOOKUP, wrap_keys[5], 32'd0);
      send_item(lph_pkg::OP_REMOVE, wrap_keys[2], wrap_handles[2]);
      send_item(lph_pkg::OP_LOOKUP, wrap_keys[5], 32'd0);
      send_item(lph_pkg::OP_CLEAR, '1, '1);
      send_item(lph_pkg::OP_LOOKUP, 32'd0, 32'd0);

      for (i = 0; i < 500; i++) begin
         if (i == 150) hold_left = 400;
         if (i == 300) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_count != 0) @(negedge clock);
         end
         send_mixed(4, 3, 2);
      end

      // Fill the table past its load limit with no idling on either side.
      send_item(lph_pkg::OP_CLEAR, $urandom, $urandom);
      pool_key.delete();
      pool_handle.delete();
      quiet = 1'b1;
      repeat (800) begin
         k = fresh_key();
         h = $urandom;
         send_item(lph_pkg::OP_INSERT, k, h);
         pool_key.push_back(k);
         pool_handle.push_back(h);
      end
      repeat (6) send_item(lph_pkg::OP_INSERT, pool_key[$urandom_range(0, 99)], $urandom);
      repeat (4) send_item(lph_pkg::OP_INSERT, fresh_key(), $urandom);
      quiet = 1'b0;

      repeat (400) send_mixed(3, 3, 3);

      send_item(lph_pkg::OP_CLEAR, $urandom, $urandom);
      pool_key.delete();
      pool_handle.delete();
      repeat (100) send_mixed(2, 2, 2);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/lph_pkg.sv
design/lph_ram.sv
design/lph_hash.sv
design/lph_ctrl.sv
design/linear_probe_hash_index.sv
dv/linear_probe_hash_index_checker.sv
dv/linear_probe_hash_index_tb.sv
